// File: hw/rtl/lbhist_pkg.sv
// Shared types, constants and the bucket bound table for the latency histogram.
// Depends on nothing; every other file of the block imports it.
package lbhist_pkg;

   localparam int NUM_BUCKETS    = 16;
   localparam int BKT_W          = 4;
   localparam int DATA_W         = 32;
   localparam int PCT_W          = 7;
   localparam int CMD_W          = 2;
   localparam int REQ_TDATA_W    = 104;
   localparam int RSP_TDATA_W    = 128;
   localparam int COUNT_BITS_DEF = 32;

   // cycles -> microseconds, rounded: (cycles + 50) / 100 by reciprocal multiply.
   // x / 100 = (x >> 2) / 25, and (y * ceil(2^35 / 25)) >> 35 is exact for y < 2^32.
   localparam int               TICKS_PER_USEC = 100;
   localparam int               ROUND_ADD      = TICKS_PER_USEC / 2;
   localparam int               DIV_IN_W       = DATA_W + 1;
   localparam int               RCP_IN_W       = DIV_IN_W - 2;   // factor 4 shifted out
   localparam int               RCP_W          = 31;
   localparam logic [RCP_W-1:0] RCP_DIV25      = 31'h51EB_851F;
   localparam int               RCP_SHIFT      = 35;
   localparam int               RCP_PROD_W     = RCP_IN_W + RCP_W;

   // percent scale of the target test
   localparam int PCT_SCALE = 100;

   typedef enum logic [CMD_W-1:0] {
      CMD_REC_US  = 2'd0,
      CMD_REC_CYC = 2'd1,
      CMD_QUERY   = 2'd2,
      CMD_CLEAR   = 2'd3
   } lbhist_cmd_code_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch beat fields, prime scaler and walk
      logic clear;      // zero the histogram
      logic div_step;   // register the scaled quotient
      logic bin;        // register sample and its bucket index
      logic record;     // bump bucket, total, max, first stamp
      logic walk_add;   // accumulate the current bucket
      logic walk_next;  // advance to the next bucket
      logic load_rsp;   // load the output register
   } lbhist_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_done;  // target reached or last bucket summed
      logic empty;      // no samples recorded
   } lbhist_sts_type;

   function automatic logic [DATA_W-1:0] bucket_bound(input logic [BKT_W-1:0] idx);
      logic [DATA_W-1:0] b;
      unique case (idx)
         4'd0:    b = 32'd10;
         4'd1:    b = 32'd20;
         4'd2:    b = 32'd50;
         4'd3:    b = 32'd100;
         4'd4:    b = 32'd200;
         4'd5:    b = 32'd500;
         4'd6:    b = 32'd1000;
         4'd7:    b = 32'd2000;
         4'd8:    b = 32'd5000;
         4'd9:    b = 32'd10000;
         4'd10:   b = 32'd20000;
         4'd11:   b = 32'd50000;
         4'd12:   b = 32'd100000;
         4'd13:   b = 32'd200000;
         4'd14:   b = 32'd500000;
         default: b = 32'hFFFF_FFFF;
      endcase
      return b;
   endfunction

endpackage

// File: hw/rtl/lbhist_ctrl.sv
// Sequencer for the latency histogram: accepts beats, steps the datapath, owns rsp valid.
// Depends on lbhist_pkg.
module lbhist_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  lbhist_pkg::lbhist_cmd_code_type  req_cmd,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output lbhist_pkg::lbhist_cmd_type       cmd,
   input  lbhist_pkg::lbhist_sts_type       sts
);
   import lbhist_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_BIN,
      ST_REC,
      ST_ADD,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (req_cmd)
                  CMD_REC_US:  state_in = ST_BIN;
                  CMD_REC_CYC: state_in = ST_DIV;
                  CMD_QUERY:   state_in = ST_ADD;
                  CMD_CLEAR:   cmd.clear = 1'b1;
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_BIN;
         end
         ST_BIN: begin
            cmd.bin  = 1'b1;
            state_in = ST_REC;
         end
         ST_REC: begin
            cmd.record = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_ADD: begin
            cmd.walk_add = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = ST_ADD;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: hw/rtl/lbhist_dp.sv
// Datapath for the latency histogram: bucket counters, cycle-to-microsecond scaling,
// percentile walk, output register. Depends on lbhist_pkg; driven by lbhist_ctrl.
module lbhist_dp #(
   parameter int COUNT_BITS = lbhist_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lbhist_pkg::lbhist_cmd_code_type      req_cmd,
   input  logic [lbhist_pkg::DATA_W-1:0]        req_lat_us,
   input  logic [lbhist_pkg::DATA_W-1:0]        req_elapsed_cycles,
   input  logic [lbhist_pkg::DATA_W-1:0]        req_now_ms,
   input  logic [lbhist_pkg::PCT_W-1:0]         req_percent,
   input  lbhist_pkg::lbhist_cmd_type           cmd,
   output lbhist_pkg::lbhist_sts_type           sts,
   output logic [lbhist_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import lbhist_pkg::*;

   localparam int CUM_W    = COUNT_BITS + BKT_W;      // sum of all buckets
   localparam int CUM100_W = CUM_W + PCT_W;           // that sum times 100
   localparam int PROD_W   = COUNT_BITS + PCT_W;      // total times percent
   localparam int SAT_W    = (CUM_W > 64) ? CUM_W : 64;
   localparam int TOT_W    = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W;

   // architectural state
   logic [COUNT_BITS-1:0] bkt_ff [NUM_BUCKETS];
   logic [COUNT_BITS-1:0] total_ff;
   logic [DATA_W-1:0]     largest_ff;
   logic [DATA_W-1:0]     first_ff;

   // per-beat working registers
   logic                  cyc_sel_ff;
   logic [DATA_W-1:0]     sample_ff;
   logic [DATA_W-1:0]     now_ff;
   logic [DATA_W-1:0]     us_ff, us_sel;
   logic [BKT_W-1:0]      idx_ff, idx_of_us;
   logic [DIV_IN_W-1:0]   div_num_ff;
   logic [DATA_W-1:0]     div_quo_ff;
   logic [RCP_PROD_W-1:0] div_prod;
   logic [PROD_W-1:0]     prod_ff;
   logic [CUM_W-1:0]      cum_ff;
   logic [CUM100_W-1:0]   cum100_ff;
   logic [COUNT_BITS-1:0] bkt_rd;
   logic [SAT_W-1:0]      cum_wide;
   logic [TOT_W-1:0]      tot_wide;
   logic                  hit, last;
   logic [DATA_W-1:0]     pctl;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   assign bkt_rd = bkt_ff[idx_ff];

   // (cycles + 50) / 100 as ((cycles + 50) >> 2) * ceil(2^35 / 25) >> 35
   assign div_prod = RCP_PROD_W'(div_num_ff[DIV_IN_W-1:2]) * RCP_PROD_W'(RCP_DIV25);

   assign us_sel = cyc_sel_ff ? div_quo_ff : sample_ff;

   always_comb begin
      idx_of_us = BKT_W'(NUM_BUCKETS - 1);
      for (int b = NUM_BUCKETS - 2; b >= 0; b--) begin
         if (us_sel < bucket_bound(BKT_W'(b))) idx_of_us = BKT_W'(b);
      end
   end

   // target test without a divide: ceil(T*p/100) <= cum  <=>  T*p <= 100*cum.
   // Sums at or past 2^64-1 always meet the (64-bit saturated) target.
   assign cum_wide = SAT_W'(cum_ff);
   assign last     = (idx_ff == BKT_W'(NUM_BUCKETS - 1));
   assign hit      = (cum_ff != '0) &&
                     ((cum_wide >= SAT_W'(64'hFFFF_FFFF_FFFF_FFFF)) ||
                      (cum100_ff >= CUM100_W'(prod_ff)));
   assign pctl     = (hit && !last) ? bucket_bound(idx_ff) : largest_ff;
   assign tot_wide = TOT_W'(total_ff);

   assign sts.walk_done = hit || last;
   assign sts.empty     = (total_ff == '0);
   assign rsp_tdata     = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) bkt_ff[b] <= '0;
         total_ff   <= '0;
         largest_ff <= '0;
         first_ff   <= '0;
      end else if (cmd.clear) begin
         for (int b = 0; b < NUM_BUCKETS; b++) bkt_ff[b] <= '0;
         total_ff   <= '0;
         largest_ff <= '0;
         first_ff   <= '0;
      end else if (cmd.record) begin
         if (total_ff == '0) first_ff <= now_ff;
         if (bkt_rd != '1) bkt_ff[idx_ff] <= bkt_rd + 1'b1;
         if (total_ff != '1) total_ff <= total_ff + 1'b1;
         if (us_ff > largest_ff) largest_ff <= us_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cyc_sel_ff <= (req_cmd == CMD_REC_CYC);
         sample_ff  <= req_lat_us;
         now_ff     <= req_now_ms;
         div_num_ff <= DIV_IN_W'(req_elapsed_cycles) + DIV_IN_W'(ROUND_ADD);
         prod_ff    <= PROD_W'(total_ff) * PROD_W'(req_percent);
         cum_ff     <= '0;
         cum100_ff  <= '0;
         idx_ff     <= '0;
      end else begin
         if (cmd.div_step) begin
            div_quo_ff <= DATA_W'(div_prod[RCP_PROD_W-1:RCP_SHIFT]);
         end
         if (cmd.bin) begin
            us_ff  <= us_sel;
            idx_ff <= idx_of_us;
         end
         if (cmd.walk_add) begin
            cum_ff    <= cum_ff + CUM_W'(bkt_rd);
            cum100_ff <= cum100_ff + CUM100_W'(bkt_rd) * CUM100_W'(PCT_SCALE);
         end
         if (cmd.walk_next) idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_tdata_ff <= {first_ff, tot_wide[DATA_W-1:0], largest_ff, pctl};
      end
   end

endmodule

// File: hw/rtl/log_bucket_latency_histogram.sv
// Top level of the log-bucket latency histogram: controller plus datapath.
// Depends on lbhist_pkg, lbhist_ctrl and lbhist_dp.
//
// Usage
//  req_ channel: one beat per command. tuser carries the command (record us,
//    record cycles, query, clear); tdata carries lat_us, elapsed_cycles,
//    now_ms and percent. Only a query produces a rsp_ beat.
//  rsp_ channel: percentile_us, largest_us, total_samples (low 32 bits of
//    the count) and first_time_ms of the histogram at the query.
//  Steps: a record of microseconds bins the sample, then updates the
//    histogram; a record of cycles first scales by the reciprocal of 100,
//    then bins and updates. A query walks the buckets, an add step and a
//    check step for each, then loads the output register. A clear is done
//    on the accepting edge. req_tready is high only while idle.
//  Stall: the result sits in an output register; the next beat is taken
//    while it waits. A second query that finishes before the first result is
//    taken holds in its last step until the register frees.
//  Reset: synchronous, active high; histogram, count, maximum and first
//    stamp clear to zero, rsp_tvalid drops, the block is ready at once.
module log_bucket_latency_histogram #(
   parameter int COUNT_BITS = lbhist_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] command
   input  logic [lbhist_pkg::CMD_W-1:0]        req_tuser,
   // [31:0] lat_us, [63:32] elapsed_cycles, [95:64] now_ms,
   // [102:96] percent, [103] zero
   input  logic [lbhist_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] percentile_us, [63:32] largest_us, [95:64] total_samples,
   // [127:96] first_time_ms
   output logic [lbhist_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import lbhist_pkg::*;

   lbhist_cmd_type      cmd;
   lbhist_sts_type      sts;
   lbhist_cmd_code_type req_cmd;

   assign req_cmd = lbhist_cmd_code_type'(req_tuser);

   lbhist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lbhist_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_lat_us         (req_tdata[31:0]),
      .req_elapsed_cycles (req_tdata[63:32]),
      .req_now_ms         (req_tdata[95:64]),
      .req_percent        (req_tdata[102:96]),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_tdata          (rsp_tdata)
   );

   // a query keeps the sequencer busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_cmd == CMD_QUERY) |=> !req_tready)
      else $error("beat accepted straight after a query");

   // clear empties the histogram
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_cmd == CMD_CLEAR) |=> sts.empty)
      else $error("histogram not empty after clear");

   // a result only appears once the walk has finished
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(sts.walk_done))
      else $error("result raised before the bucket walk finished");

   // record beats never produce a result
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_cmd != CMD_QUERY && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result raised by a non-query beat");

endmodule

// File: sim/log_bucket_latency_histogram_test.sv
// Self-checking bench for log_bucket_latency_histogram: random record, query and clear beats
// are checked against a cycle-free copy of the histogram kept in a small scoreboard class.
// Depends on lbhist_pkg and the RTL of the block; reads no files.
module log_bucket_latency_histogram_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lbhist_pkg::*;

   localparam int          COUNT_W     = 32;
   localparam logic [63:0] COUNT_MAX   = (64'd1 << COUNT_W) - 64'd1;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          RANDOM_BEATS = 1200;
   localparam int          IDLE_LIMIT  = 4000;  // cycles without any handshake
   localparam int          LONG_HOLD   = 300;   // receiver hold-off for the back-pressure test
   localparam int          TAIL_CYCLES = 100;   // idle time after the final drain

   // upper bounds of buckets 0..14; bucket 15 is open
   localparam logic [31:0] BUCKET_TOP [NUM_BUCKETS] = '{
      32'd10, 32'd20, 32'd50, 32'd100, 32'd200, 32'd500, 32'd1000, 32'd2000,
      32'd5000, 32'd10000, 32'd20000, 32'd50000, 32'd100000, 32'd200000,
      32'd500000, 32'hFFFF_FFFF
   };

   // request tdata, lowest field last in the declaration
   typedef struct packed {
      logic        pad;
      logic [6:0]  percent;
      logic [31:0] now_ms;
      logic [31:0] elapsed_cycles;
      logic [31:0] lat_us;
   } histogram_request_type;

   // response tdata, lowest field last in the declaration
   typedef struct packed {
      logic [31:0] first_time_ms;
      logic [31:0] total_samples;
      logic [31:0] largest_us;
      logic [31:0] percentile_us;
   } histogram_answer_type;

   // Mirror of the histogram plus the queue of answers still owed by the block.
   class latency_histogram_tracker_type;
      logic [63:0]          bucket_hits [NUM_BUCKETS];
      logic [31:0]          peak_us;
      logic [63:0]          sample_count;
      logic [31:0]          first_ms;
      histogram_answer_type pending_answers [$];
      int                   failures;

      function new();
         failures = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (bucket_hits[b])
            bucket_hits[b] = '0;
         peak_us      = '0;
         sample_count = '0;
         first_ms     = '0;
      endfunction

      function void add_sample(logic [31:0] us, logic [31:0] now);
         int b;
         int k;
         if (sample_count == 0)
            first_ms = now;
         b = NUM_BUCKETS - 1;
         for (k = NUM_BUCKETS - 2; k >= 0; k--)
            if (us < BUCKET_TOP[k])
               b = k;
         if (bucket_hits[b] < COUNT_MAX)
            bucket_hits[b]++;
         if (us > peak_us)
            peak_us = us;
         if (sample_count < COUNT_MAX)
            sample_count++;
      endfunction

      // ceil(count * pct / 100), at least 1, saturating at 64 bits
      function logic [63:0] rank_target(logic [6:0] pct);
         logic [63:0] p;
         logic [63:0] q;
         logic [63:0] r;
         logic [63:0] hi;
         logic [63:0] lo;
         logic [63:0] t;
         p = {57'd0, pct};
         q = sample_count / 64'd100;
         r = sample_count % 64'd100;
         if (p != 0 && q > ALL_ONES / p)
            return ALL_ONES;
         hi = q * p;
         lo = (r * p + 64'd99) / 64'd100;
         t  = hi + lo;
         if (t < hi)
            t = ALL_ONES;
         if (t == 0)
            t = 64'd1;
         return t;
      endfunction

      function logic [31:0] predict_percentile(logic [6:0] pct);
         logic [63:0] target;
         logic [63:0] running;
         logic [63:0] sum;
         int          b;
         if (sample_count == 0)
            return 32'd0;
         target  = rank_target(pct);
         running = '0;
         for (b = 0; b < NUM_BUCKETS; b++) begin
            sum     = running + bucket_hits[b];
            running = (sum < running) ? ALL_ONES : sum;
            if (running >= target)
               return (b == NUM_BUCKETS - 1) ? peak_us : BUCKET_TOP[b];
         end
         // percent above 100 can outrun every cumulative sum
         return peak_us;
      endfunction

      function void note_request(lbhist_cmd_code_type cmd, histogram_request_type req);
         logic [63:0]          wide;
         histogram_answer_type ans;
         case (cmd)
            CMD_REC_US: begin
               add_sample(req.lat_us, req.now_ms);
            end
            CMD_REC_CYC: begin
               // rounded divide in a wide sum so the +50 cannot wrap
               wide = ({32'd0, req.elapsed_cycles} + 64'd50) / 64'd100;
               add_sample(wide[31:0], req.now_ms);
            end
            CMD_QUERY: begin
               ans.percentile_us = predict_percentile(req.percent);
               ans.largest_us    = peak_us;
               ans.total_samples = sample_count[31:0];
               ans.first_time_ms = first_ms;
               pending_answers.push_back(ans);
            end
            default: begin
               wipe();
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(histogram_answer_type got);
         histogram_answer_type want;
         if (pending_answers.size() == 0) begin
            $error("response beat with no query outstanding (percentile_us %0d)",
                   got.percentile_us);
            failures++;
            return;
         end
         want = pending_answers.pop_front();
         compare_field("percentile_us", want.percentile_us, got.percentile_us);
         compare_field("largest_us", want.largest_us, got.largest_us);
         compare_field("total_samples", want.total_samples, got.total_samples);
         compare_field("first_time_ms", want.first_time_ms, got.first_time_ms);
      endfunction

      function int waiting();
         return pending_answers.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------------------------
   // Clock, reset and the block
   // ---------------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CMD_W-1:0]       req_tuser  = CMD_REC_US;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // lat_us, elapsed_cycles, now_ms, percent, zero
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // percentile_us, largest_us, total_samples, first_time_ms

   always #6 clock = ~clock;

   log_bucket_latency_histogram #(
      .COUNT_BITS (COUNT_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   latency_histogram_tracker_type tracker;

   // ---------------------------------------------------------------------------------------
   // Receiver: checks every response beat, stalls on a rotating 16-bit mask that is redrawn
   // whenever its 6-bit phase counter wraps (all ones now and then, so there are stretches
   // without stalls). A bump of rsp_hold_req from the stimulus starts one long hold-off counted here.
   // ---------------------------------------------------------------------------------------
   int          rsp_hold_req  = 0;
   int          rsp_hold_seen = 0;
   int          hold_left     = 0;
   logic [15:0] ready_mask    = '1;
   logic [5:0]  ready_phase   = '0;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(histogram_answer_type'(rsp_tdata));
      if (rsp_hold_req != rsp_hold_seen) begin
         rsp_hold_seen = rsp_hold_req;
         hold_left     = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (ready_phase == 0) begin
            case ($urandom_range(0, 3))
               0:       ready_mask = '1;
               1:       ready_mask = 16'($urandom);
               2:       ready_mask = 16'($urandom) | 16'($urandom);
               default: ready_mask = 16'($urandom) & 16'($urandom);
            endcase
         end
         rsp_tready  <= ready_mask[ready_phase[3:0]];
         ready_phase <= ready_phase + 6'd1;
      end
   end

   // Watchdog: a run that stops moving is a failure.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[log_bucket_latency_histogram] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------------------
   int   burst_left = 0;
   logic no_gaps    = 1'b0;

   // Offers one beat, opening a new burst with a random gap when the last one is used up.
   // Called in the time step of a rising edge; returns in the step of the accepting edge.
   task automatic offer(lbhist_cmd_code_type cmd, histogram_request_type req);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = no_gaps ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= req;
      do
         @(posedge clock);
      while (!req_tready);
      tracker.note_request(cmd, req);
   endtask

   // Drops valid and waits until every owed answer has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do
         @(posedge clock);
      while (tracker.waiting() != 0);
   endtask

   task automatic offer_fields(lbhist_cmd_code_type cmd, logic [31:0] us, logic [31:0] cyc,
                               logic [31:0] now, logic [6:0] pct);
      histogram_request_type req;
      req = '{pad: 1'b0, percent: pct, now_ms: now, elapsed_cycles: cyc, lat_us: us};
      offer(cmd, req);
   endtask

   function automatic histogram_request_type random_request();
      histogram_request_type req;
      req.pad            = 1'b0;
      req.percent        = 7'($urandom_range(0, 127));
      req.now_ms         = $urandom;
      req.elapsed_cycles = $urandom;
      req.lat_us         = $urandom;
      return req;
   endfunction

   // samples spread over every decade, with plenty right at the bucket edges
   function automatic logic [31:0] pick_micros();
      int k;
      k = $urandom_range(0, NUM_BUCKETS - 2);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom >> $urandom_range(0, 31);
         4, 5, 6:    return BUCKET_TOP[k] + $urandom_range(0, 2) - 1;
         7:          return $urandom_range(0, 25);
         8:          return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
         default:    return $urandom;
      endcase
   endfunction

   // cycle counts around the rounding point of each bucket edge, plus the top of the range
   function automatic logic [31:0] pick_cycles();
      int k;
      k = $urandom_range(0, NUM_BUCKETS - 2);
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom >> $urandom_range(0, 31);
         2:       return BUCKET_TOP[k] * 100 + $urandom_range(0, 100) - 50;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 200);
      endcase
   endfunction

   function automatic logic [6:0] pick_percent();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return 7'($urandom_range(0, 100));
         7: begin
            case ($urandom_range(0, 2))
               0:       return 7'd50;
               1:       return 7'd95;
               default: return 7'd99;
            endcase
         end
         8:       return 7'($urandom_range(101, 127));  // past 100: may miss every sum
         default: return ($urandom_range(0, 1) != 0) ? 7'd100 : 7'd0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      histogram_request_type req;
      lbhist_cmd_code_type   cmd;
      int                    n;
      int                    pick;

      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty query, bucket edges, both ends of every field, clear and refill
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd50);   // empty answers 0
      offer_fields(CMD_REC_US,  32'd0, $urandom, 32'hFFFF_FFFF, 7'd0);  // first stamp taken
      offer_fields(CMD_REC_US,  32'd9, $urandom, 32'd0, 7'd127);        // stamp kept
      offer_fields(CMD_REC_US,  32'd10, $urandom, $urandom, 7'd0);
      offer_fields(CMD_REC_US,  32'd499999, $urandom, $urandom, 7'd0);
      offer_fields(CMD_REC_US,  32'd500000, $urandom, $urandom, 7'd0);   // open bucket
      offer_fields(CMD_REC_US,  32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 7'd0);
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd0);     // target raised to 1
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd100);   // lands in open bucket
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd127);   // beyond every sum
      offer_fields(CMD_REC_CYC, $urandom, 32'd0, $urandom, 7'd0);
      offer_fields(CMD_REC_CYC, $urandom, 32'd49, $urandom, 7'd0);       // rounds down to 0
      offer_fields(CMD_REC_CYC, $urandom, 32'd50, $urandom, 7'd0);       // rounds up to 1
      offer_fields(CMD_REC_CYC, $urandom, 32'hFFFF_FFFF, $urandom, 7'd0); // no wrap in +50
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd50);
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd99);
      offer_fields(CMD_CLEAR,   $urandom, $urandom, $urandom, 7'd0);
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd127);   // empty after clear
      offer_fields(CMD_REC_CYC, $urandom, 32'd999949, 32'h1234_5678, 7'd0);
      offer_fields(CMD_REC_US,  32'd20, $urandom, 32'd5, 7'd0);
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd1);
      offer_fields(CMD_CLEAR,   $urandom, $urandom, $urandom, 7'd0);
      offer_fields(CMD_QUERY,   $urandom, $urandom, $urandom, 7'd0);
      drain();

      // random: mostly records with queries mixed in; clears are rare so the histogram fills
      for (n = 0; n < RANDOM_BEATS; n++) begin
         // long receiver hold-off while a run of queries is pushed back to back: the output
         // register fills, a second query parks and req_tready drops
         if (n == 400)
            rsp_hold_req++;
         no_gaps = (n >= 400 && n < 420) || (n >= 600 && n < 700);
         // sender pause until every answer is home
         if (n == 800)
            drain();

         pick = $urandom_range(0, 99);
         if (n >= 400 && n < 416)
            cmd = CMD_QUERY;
         else if (pick < 35)
            cmd = CMD_REC_US;
         else if (pick < 60)
            cmd = CMD_REC_CYC;
         else if (pick < 97)
            cmd = CMD_QUERY;
         else
            cmd = CMD_CLEAR;

         req = random_request();
         case (cmd)
            CMD_REC_US:  req.lat_us         = pick_micros();
            CMD_REC_CYC: req.elapsed_cycles = pick_cycles();
            CMD_QUERY:   req.percent        = pick_percent();
            default:     ;
         endcase
         offer(cmd, req);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.waiting() == 0)
         $display("[log_bucket_latency_histogram] OK");
      else
         $display("[log_bucket_latency_histogram] ERROR");
      $finish;
   end

endmodule
